/* hdl/elu_pkg.sv */
// Shared constants, types and the exponential seed table for the ELU activation unit.
`default_nettype none

package elu_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int FRACTION_BITS = 8;
  localparam int TDATA_WIDTH   = ((DATA_WIDTH + 7) / 8) * 8;

  localparam int ALPHA_WIDTH   = 16;
  localparam int ALPHA_FRAC    = 12;
  localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET = ALPHA_WIDTH'(4096);

  // exp() accumulator: unsigned, ACC_FRAC fraction bits, range [0, 1.0]
  localparam int ACC_FRAC      = 30;
  localparam int P_WIDTH       = ACC_FRAC + 1;
  localparam int TAYLOR_TERMS  = 16;

  // Integer part of the negated input; above N_LIMIT the exponential is zero
  localparam int INT_WIDTH     = DATA_WIDTH - FRACTION_BITS;
  localparam int N_LIMIT       = 31;
  localparam int N_WIDTH       = 5;

  // exp(-1) steps; a full-scale seed decays to zero within 23 rounded steps
  localparam int MUL_STAGES    = 24;

  localparam int FRAC_ENTRIES  = 2 ** FRACTION_BITS;
  localparam int MUL_WIDTH     = 2 * P_WIDTH;
  localparam int PROD_WIDTH    = P_WIDTH + ALPHA_WIDTH;
  localparam int SCALE_SHIFT   = ACC_FRAC + ALPHA_FRAC - FRACTION_BITS;

  typedef logic [P_WIDTH-1:0] p_t;
  typedef logic [FRAC_ENTRIES-1:0][P_WIDTH-1:0] seed_table_t;

  localparam p_t ACC_ONE = P_WIDTH'(64'd1 << ACC_FRAC);

  // One item in flight through the exponential chain
  typedef struct packed {
    logic                    pass;
    logic [DATA_WIDTH-1:0]   raw;
    logic                    last;
    logic [N_WIDTH-1:0]      n;
    p_t                      p;
  } elu_item_t;

  // Elaboration only: alternating Taylor series of exp(-f), f in [0, 1.0]
  function automatic logic [63:0] exp_neg_acc(input logic [63:0] f);
    logic signed [63:0] sum;
    logic [63:0]        term;
    logic [63:0]        one;
    one  = 64'd1 << ACC_FRAC;
    sum  = signed'(one);
    term = one;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * f) >> ACC_FRAC) / 64'(k);
      if (k[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > signed'(one)) begin
      sum = signed'(one);
    end
    return unsigned'(sum);
  endfunction

  function automatic seed_table_t build_seed_table();
    seed_table_t t;
    for (int i = 0; i < FRAC_ENTRIES; i++) begin
      t[i] = P_WIDTH'(exp_neg_acc(64'(i) << (ACC_FRAC - FRACTION_BITS)));
    end
    return t;
  endfunction

  localparam seed_table_t SEED_TABLE = build_seed_table();
  localparam p_t          EXP_M1     = P_WIDTH'(exp_neg_acc(64'd1 << ACC_FRAC));

endpackage

`default_nettype wire

/* hdl/elu_seed.sv */
// Input stage: splits a negative sample into integer and fraction parts, looks up exp(-fraction); others pass.
`default_nettype none

module elu_seed (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [elu_pkg::DATA_WIDTH-1:0] sample,
  input  wire logic                           last,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output elu_pkg::elu_item_t                  out_item
);
  import elu_pkg::*;

  logic                         en;
  logic                         neg;
  logic [DATA_WIDTH-1:0]        mag_in;
  logic [INT_WIDTH-1:0]         n_full;
  logic [FRACTION_BITS-1:0]     fr;
  logic                         big;
  elu_item_t                    item_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign neg    = sample[DATA_WIDTH-1];
  assign mag_in = ~sample + 1'b1;
  assign n_full = mag_in[DATA_WIDTH-1:FRACTION_BITS];
  assign fr     = mag_in[FRACTION_BITS-1:0];
  assign big    = n_full > INT_WIDTH'(N_LIMIT);

  always_comb begin
    item_next.pass = !neg;
    item_next.raw  = sample;
    item_next.last = last;
    item_next.n    = '0;
    item_next.p    = '0;
    if (neg) begin
      item_next.n = N_WIDTH'(n_full);
      item_next.p = big ? '0 : SEED_TABLE[fr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/elu_mul.sv */
// One exp(-1) step: if the integer count is non-zero, multiply by exp(-1) with rounding and decrement it.
`default_nettype none

module elu_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire elu_pkg::elu_item_t in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output elu_pkg::elu_item_t out_item
);
  import elu_pkg::*;

  localparam logic [MUL_WIDTH-1:0] HALF = MUL_WIDTH'(1) << (ACC_FRAC - 1);

  logic                 en;
  logic [MUL_WIDTH-1:0] prod;
  logic [MUL_WIDTH-1:0] rounded;
  elu_item_t            item_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign prod    = MUL_WIDTH'(in_item.p) * MUL_WIDTH'(EXP_M1);
  assign rounded = prod + HALF;

  always_comb begin
    item_next = in_item;
    if (in_item.n != '0) begin
      item_next.p = P_WIDTH'(rounded >> ACC_FRAC);
      item_next.n = in_item.n - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/elu_scale.sv */
// Output stages: scale (1 - exp) by alpha, round, saturate, negate, and hold the result for the master side.
`default_nettype none

module elu_scale (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [elu_pkg::ALPHA_WIDTH-1:0] alpha,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire elu_pkg::elu_item_t              in_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [elu_pkg::DATA_WIDTH-1:0]       sample,
  output logic                                 last
);
  import elu_pkg::*;

  localparam int RND_WIDTH = PROD_WIDTH + 1;
  localparam logic [RND_WIDTH-1:0] RND_HALF = RND_WIDTH'(1) << (SCALE_SHIFT - 1);
  localparam logic [RND_WIDTH-1:0] MAG_LIM  = RND_WIDTH'(1) << (DATA_WIDTH - 1);

  // stage 1: product
  logic                   v1;
  logic                   pass1;
  logic [DATA_WIDTH-1:0]  raw1;
  logic                   last1;
  logic [PROD_WIDTH-1:0]  prod1;
  logic                   en1;
  logic                   en2;
  p_t                     diff;
  logic [PROD_WIDTH-1:0]  prod_next;

  // stage 2: rounding, saturation, sign
  logic [RND_WIDTH-1:0]   rnd;
  logic [RND_WIDTH-1:0]   mag_full;
  logic [RND_WIDTH-1:0]   mag_sat;
  logic [DATA_WIDTH-1:0]  mag_lo;
  logic [DATA_WIDTH-1:0]  sample_next;

  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign diff      = ACC_ONE - in_item.p;
  assign prod_next = PROD_WIDTH'(diff) * PROD_WIDTH'(alpha);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      pass1 <= in_item.pass;
      raw1  <= in_item.raw;
      last1 <= in_item.last;
      prod1 <= prod_next;
    end
  end

  assign rnd         = RND_WIDTH'(prod1) + RND_HALF;
  assign mag_full    = rnd >> SCALE_SHIFT;
  assign mag_sat     = (mag_full > MAG_LIM) ? MAG_LIM : mag_full;
  assign mag_lo      = mag_sat[DATA_WIDTH-1:0];
  assign sample_next = pass1 ? raw1 : (~mag_lo + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      sample <= sample_next;
      last   <= last1;
    end
  end

endmodule

`default_nettype wire

/* hdl/elu_activation_unit.sv */
// ELU activation top level: config register, seed stage, exp(-1) chain and output scaling.
// Stages: 1 seed register, 24 exp step registers and 2 scale registers, in that order.
// Throughput: one sample per cycle while m_tready is high; each stage holds while its successor is full and stalled.
// Bubbles close up under back-pressure, so input is taken while any stage is empty.
// Reset: synchronous, active high; clears all valid bits and sets alpha_gain to 1.0 (4096).
`default_nettype none

module elu_activation_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [elu_pkg::TDATA_WIDTH-1:0] s_tdata,   // [15:0] sample_in
  input  wire logic                            s_tlast,   // end_of_vector
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [elu_pkg::TDATA_WIDTH-1:0]      m_tdata,   // [15:0] sample_out
  output logic                                 m_tlast,   // last_out
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [elu_pkg::ALPHA_WIDTH-1:0] cfg_data   // alpha_gain, Q4.12
);
  import elu_pkg::*;

  logic [ALPHA_WIDTH-1:0] alpha_gain;

  logic      stg_valid [MUL_STAGES+1];
  logic      stg_ready [MUL_STAGES+1];
  elu_item_t stg_item  [MUL_STAGES+1];

  logic [DATA_WIDTH-1:0] sample_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= ALPHA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      alpha_gain <= cfg_data;
    end
  end

  elu_seed u_seed (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sample    (s_tdata[DATA_WIDTH-1:0]),
    .last      (s_tlast),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_item  (stg_item[0])
  );

  for (genvar i = 0; i < MUL_STAGES; i++) begin : g_mul
    elu_mul u_mul (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_item   (stg_item[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_item  (stg_item[i+1])
    );
  end

  elu_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .alpha     (alpha_gain),
    .in_valid  (stg_valid[MUL_STAGES]),
    .in_ready  (stg_ready[MUL_STAGES]),
    .in_item   (stg_item[MUL_STAGES]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sample    (sample_res),
    .last      (m_tlast)
  );

  assign m_tdata = TDATA_WIDTH'(sample_res);

  // the chain must be long enough for every seed to have decayed or finished its steps
  a_chain_done: assert property (@(posedge clk) disable iff (rst)
    stg_valid[MUL_STAGES] && !stg_item[MUL_STAGES].pass
      |-> (stg_item[MUL_STAGES].n == '0) || (stg_item[MUL_STAGES].p == '0))
    else $error("exp chain ended with steps left and non-zero value");

  a_p_range: assert property (@(posedge clk) disable iff (rst)
    stg_valid[MUL_STAGES] |-> stg_item[MUL_STAGES].p <= ACC_ONE)
    else $error("exp value above 1.0");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output side is ready");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> alpha_gain == $past(cfg_data))
    else $error("alpha_gain not updated by config transaction");

endmodule

`default_nettype wire
